// ===== rtl/clbs_pkg.sv =====
// Shared types, command and register codes, wait figures and the item generator
// for the character LCD bus sequencer. No dependencies.
`default_nettype none

package clbs_pkg;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_CLEAR = 3'd1;
  localparam logic [2:0] CMD_HOME  = 3'd2;
  localparam logic [2:0] CMD_MOVE  = 3'd3;
  localparam logic [2:0] CMD_WRITE = 3'd4;

  localparam logic [1:0] REG_FOUR_BIT = 2'd0;
  localparam logic [1:0] REG_COLUMNS  = 2'd1;
  localparam logic [1:0] REG_ROWS     = 2'd2;

  localparam logic [7:0] INS_FUNC_SET   = 8'h20;
  localparam logic [7:0] INS_TWO_LINE   = 8'h08;
  localparam logic [7:0] INS_EIGHT_BIT  = 8'h10;
  localparam logic [7:0] INS_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] INS_CLEAR      = 8'h01;
  localparam logic [7:0] INS_HOME       = 8'h02;
  localparam logic [7:0] INS_ENTRY_MODE = 8'h06;
  localparam logic [7:0] INS_DDRAM      = 8'h80;
  localparam logic [6:0] ROW_ONE_OFFSET = 7'h40;

  localparam logic [7:0] WAKE_NIBBLE   = 8'h03;
  localparam logic [7:0] FOUR_BIT_NIB  = 8'h02;

  localparam logic [15:0] WAIT_POWER_ON = 16'd50000;
  localparam logic [15:0] WAIT_WAKE4    = 16'd4601;
  localparam logic [15:0] WAIT_WAKE8    = 16'd4600;
  localparam logic [15:0] WAIT_WAKE_2ND = 16'd250;
  localparam logic [15:0] WAIT_CMD      = 16'd100;
  localparam logic [15:0] WAIT_SLOW_CMD = 16'd2100;

  localparam logic [3:0] LAST_STEP_INIT4 = 4'd12;
  localparam logic [3:0] LAST_STEP_INIT8 = 4'd7;
  localparam logic [3:0] FIRST_TAIL4     = 4'd5;
  localparam logic [3:0] FIRST_TAIL8     = 4'd4;

  // One classified command, as it travels from front to back.
  typedef struct packed {
    logic       init;       // full power-on sequence
    logic       four_bit;   // nibble transfers
    logic       rs;         // register select for a byte transfer
    logic [7:0] value;      // byte to send, or function set for init
    logic       slow;       // final strobe waits for a slow instruction
  } job_t;

  typedef struct packed {
    logic        strobe_res;
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [15:0] wait_us;
    logic        last;
  } item_t;

  // Byte of the common set-up tail: function set, display on, clear, entry mode.
  function automatic logic [7:0] tail_byte(logic [1:0] sel, logic [7:0] fs);
    logic [7:0] b;
    case (sel)
      2'd0:    b = fs;
      2'd1:    b = INS_DISPLAY_ON;
      2'd2:    b = INS_CLEAR;
      default: b = INS_ENTRY_MODE;
    endcase
    return b;
  endfunction

  // Result item number step of the given job.
  function automatic item_t item_of(job_t j, logic [3:0] step);
    item_t      it;
    logic [3:0] idx;
    logic [7:0] b;
    it = '{strobe_res: 1'b1, reg_select: 1'b0, bus_value: 8'h00,
           wait_us: WAIT_CMD, last: 1'b0};
    idx = 4'd0;
    b = 8'h00;
    if (!j.init) begin
      it.reg_select = j.rs;
      if (j.four_bit) begin
        if (step == 4'd0) begin
          it.bus_value = {4'h0, j.value[7:4]};
        end else begin
          it.bus_value = {4'h0, j.value[3:0]};
          it.wait_us = j.slow ? WAIT_SLOW_CMD : WAIT_CMD;
          it.last = 1'b1;
        end
      end else begin
        it.bus_value = j.value;
        it.wait_us = j.slow ? WAIT_SLOW_CMD : WAIT_CMD;
        it.last = 1'b1;
      end
    end else if (step == 4'd0) begin
      it.strobe_res = 1'b0;
      it.wait_us = WAIT_POWER_ON;
    end else if (j.four_bit) begin
      if (step < FIRST_TAIL4) begin
        case (step)
          4'd1, 4'd2: begin
            it.bus_value = WAKE_NIBBLE;
            it.wait_us = WAIT_WAKE4;
          end
          4'd3: begin
            it.bus_value = WAKE_NIBBLE;
            it.wait_us = WAIT_WAKE_2ND;
          end
          default: begin
            it.bus_value = FOUR_BIT_NIB;
          end
        endcase
      end else begin
        idx = step - FIRST_TAIL4;
        b = tail_byte(idx[2:1], j.value);
        it.bus_value = idx[0] ? {4'h0, b[3:0]} : {4'h0, b[7:4]};
        it.wait_us = (idx[0] && idx[2:1] == 2'd2) ? WAIT_SLOW_CMD : WAIT_CMD;
        it.last = (step == LAST_STEP_INIT4);
      end
    end else begin
      if (step < FIRST_TAIL8) begin
        it.bus_value = j.value;
        case (step)
          4'd1:    it.wait_us = WAIT_WAKE8;
          4'd2:    it.wait_us = WAIT_WAKE_2ND;
          default: it.wait_us = WAIT_CMD;
        endcase
      end else begin
        idx = step - FIRST_TAIL8;
        it.bus_value = tail_byte(idx[1:0], j.value);
        it.wait_us = (idx[1:0] == 2'd2) ? WAIT_SLOW_CMD : WAIT_CMD;
        it.last = (step == LAST_STEP_INIT8);
      end
    end
    return it;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/clbs_front.sv =====
// Front end: configuration registers and command classification into jobs.
// Depends on clbs_pkg.
`default_nettype none

module clbs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [5:0]         cfg_data,
  input  wire logic               accept,
  input  wire logic [2:0]         command,
  input  wire logic [7:0]         data_byte,
  input  wire logic [6:0]         column,
  input  wire logic [2:0]         row,
  output logic                    push,
  output clbs_pkg::job_t          job
);

  logic       four_bit_bus;
  logic [5:0] columns;
  logic [2:0] rows;

  logic [2:0] eff_rows;
  logic [2:0] row_c;
  logic [6:0] offset;
  logic [6:0] addr;
  logic [7:0] func_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_bus <= 1'b1;
      columns <= 6'd16;
      rows <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        clbs_pkg::REG_FOUR_BIT: four_bit_bus <= cfg_data[0];
        clbs_pkg::REG_COLUMNS:  columns <= cfg_data;
        clbs_pkg::REG_ROWS:     rows <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_rows = (rows == 3'd0) ? 3'd1 : rows;
    row_c = (row >= eff_rows) ? eff_rows - 3'd1 : row;
    case (row_c)
      3'd0:    offset = 7'd0;
      3'd1:    offset = clbs_pkg::ROW_ONE_OFFSET;
      3'd2:    offset = {1'b0, columns};
      default: offset = clbs_pkg::ROW_ONE_OFFSET + {1'b0, columns};
    endcase
    addr = column + offset;
    func_set = clbs_pkg::INS_FUNC_SET
             | ((eff_rows > 3'd1) ? clbs_pkg::INS_TWO_LINE : 8'h00)
             | (four_bit_bus ? 8'h00 : clbs_pkg::INS_EIGHT_BIT);

    job = '{init: 1'b0, four_bit: four_bit_bus, rs: 1'b0, value: 8'h00, slow: 1'b0};
    push = 1'b0;
    case (command)
      clbs_pkg::CMD_INIT: begin
        job.init = 1'b1;
        job.value = func_set;
        push = accept;
      end
      clbs_pkg::CMD_CLEAR: begin
        job.value = clbs_pkg::INS_CLEAR;
        job.slow = 1'b1;
        push = accept;
      end
      clbs_pkg::CMD_HOME: begin
        job.value = clbs_pkg::INS_HOME;
        job.slow = 1'b1;
        push = accept;
      end
      clbs_pkg::CMD_MOVE: begin
        job.value = clbs_pkg::INS_DDRAM | {1'b0, addr};
        push = accept;
      end
      clbs_pkg::CMD_WRITE: begin
        job.rs = 1'b1;
        job.value = data_byte;
        push = accept;
      end
      default: ;  // drop unknown commands
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/clbs_queue.sv =====
// Short job queue between front and back ends.
// Depends on clbs_pkg for the job type.
`default_nettype none

module clbs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire clbs_pkg::job_t push_job,
  input  wire logic           pop,
  output clbs_pkg::job_t      head,
  output logic                empty,
  output logic                full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  clbs_pkg::job_t  slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clbs_back.sv =====
// Back end: walks the current job one result item per cycle into output registers.
// Depends on clbs_pkg.
`default_nettype none

module clbs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire clbs_pkg::job_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                result_strobe,
  output clbs_pkg::item_t     result
);

  clbs_pkg::job_t  cur;
  logic            cur_valid;
  logic [3:0]      step;
  clbs_pkg::item_t item;

  always_comb begin
    item = clbs_pkg::item_of(cur, step);
    pop = !empty && (!cur_valid || item.last);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (cur_valid) begin
      result <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cur_valid;
      if (pop) begin
        cur_valid <= 1'b1;
        step <= '0;
      end else if (cur_valid) begin
        if (item.last) begin
          cur_valid <= 1'b0;
        end
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/char_lcd_bus_sequencer.sv =====
// Character LCD bus sequencer: commands in, enable-strobe transactions out.
// An accepted command is registered in the job queue, then as the current job, then as a
// result; one result per cycle after that while jobs are queued. Initialise gives 13
// results (8 in 8-bit mode), a byte command 2 (1 in 8-bit); queued commands overlap.
// Reset (rst, synchronous): four_bit_bus=1, columns=16, rows=1, queue and back end emptied.
// Results cannot be stalled; each is valid for the one cycle result_strobe is high.
`default_nettype none

module char_lcd_bus_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  data_byte,
  input  wire logic [6:0]  column,
  input  wire logic [2:0]  row,
  // configuration write transaction
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  // result transaction
  output logic             result_strobe,
  output logic             strobe_res,
  output logic             reg_select,
  output logic [7:0]       bus_value,
  output logic [15:0]      wait_us,
  output logic             last
);

  logic            accept;
  logic            push;
  clbs_pkg::job_t  job;
  clbs_pkg::job_t  head;
  logic            empty;
  logic            full;
  logic            pop;
  clbs_pkg::item_t result;

  // Hold off new commands only while the job queue is full.
  assign busy = full;
  assign accept = start && !busy;
  // Configuration writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  // Classify each command into a job; drop unknown codes here.
  clbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .command   (command),
    .data_byte (data_byte),
    .column    (column),
    .row       (row),
    .push      (push),
    .job       (job)
  );

  clbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Advance through each job's items, pulling the next job on its last item.
  clbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

  assign strobe_res = result.strobe_res;
  assign reg_select = result.reg_select;
  assign bus_value  = result.bus_value;
  assign wait_us    = result.wait_us;
  assign last       = result.last;

endmodule

`default_nettype wire

// ===== verif/char_lcd_bus_sequencer_tb.sv =====
// Self-checking bench for char_lcd_bus_sequencer: queued command driver, strobe monitor
// and an independent expansion of every command into its expected bus transactions.
// Depends on clbs_pkg (command and register codes, item_t) and the RTL top level.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_tb;

  // Index 3 selects no register; writes to it must leave everything unchanged.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Bus timing in microseconds, kept apart from the RTL's own figures.
  localparam logic [15:0] US_POWER_ON   = 16'd50000;
  localparam logic [15:0] US_WAKE_NIB   = 16'd4601;
  localparam logic [15:0] US_WAKE_2ND   = 16'd250;
  localparam logic [15:0] US_BYTE       = 16'd100;
  localparam logic [15:0] US_EXTRA_WAKE = 16'd4500;
  localparam logic [15:0] US_EXTRA_2ND  = 16'd150;
  localparam logic [15:0] US_EXTRA_SLOW = 16'd2000;

  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction of any kind
  localparam int SETTLE_CYCLES = 8;    // idle wait after a drain, for an ignored command still inside the block
  localparam int NUM_PHASES   = 8;
  localparam int RANDOM_PER_PHASE = 25;

  typedef struct {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [6:0] column;
    logic [2:0] row;
  } lcd_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  command = '0;
  logic [7:0]  data_byte = '0;
  logic [6:0]  column = '0;
  logic [2:0]  row = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;
  logic        result_strobe;
  logic        strobe_res;
  logic        reg_select;
  logic [7:0]  bus_value;
  logic [15:0] wait_us;
  logic        last;

  // Bench copy of the configuration, updated on each accepted register write.
  logic        shadow_four_bit = 1'b1;
  logic [5:0]  shadow_columns = 6'd16;
  logic [2:0]  shadow_rows = 3'd1;

  lcd_cmd_t          cmd_backlog[$];      // commands waiting to be presented
  clbs_pkg::item_t   expected_strobes[$]; // bus transactions still owed by the block
  int                mismatch_count = 0;
  int                stall_cycles = 0;
  bit                gaps_enabled = 1'b1;

  char_lcd_bus_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .data_byte    (data_byte),
    .column       (column),
    .row          (row),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_strobe(result_strobe),
    .strobe_res   (strobe_res),
    .reg_select   (reg_select),
    .bus_value    (bus_value),
    .wait_us      (wait_us),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Expected-transaction expansion
  // ---------------------------------------------------------------------------

  function automatic void owe_item(logic strb, logic rs, logic [7:0] bus, logic [15:0] us);
    clbs_pkg::item_t it;
    it.strobe_res = strb;
    it.reg_select = rs;
    it.bus_value  = bus;
    it.wait_us    = us;
    it.last       = 1'b0;
    expected_strobes.push_back(it);
  endfunction

  // One byte on the bus: two nibble strobes in 4-bit mode, high nibble first.
  // The extra delay lands on the final strobe of the byte only.
  function automatic void owe_byte(logic rs, logic [7:0] v, logic [15:0] extra);
    if (shadow_four_bit) begin
      owe_item(1'b1, rs, {4'h0, v[7:4]}, US_BYTE);
      owe_item(1'b1, rs, {4'h0, v[3:0]}, US_BYTE + extra);
    end else begin
      owe_item(1'b1, rs, v, US_BYTE + extra);
    end
  endfunction

  // A rows register of zero behaves as a single-row display.
  function automatic logic [2:0] live_rows();
    return (shadow_rows == 3'd0) ? 3'd1 : shadow_rows;
  endfunction

  function automatic logic [7:0] function_set_byte();
    logic [7:0] v;
    v = 8'h20;
    if (live_rows() > 3'd1) v |= 8'h08;
    if (!shadow_four_bit) v |= 8'h10;
    return v;
  endfunction

  function automatic logic [7:0] ddram_address_byte(logic [6:0] col, logic [2:0] r);
    logic [2:0] y;
    logic [7:0] offset;
    logic [7:0] sum;
    y = r;
    if (y >= live_rows()) y = live_rows() - 3'd1;
    case (y)
      3'd0:    offset = 8'h00;
      3'd1:    offset = 8'h40;
      3'd2:    offset = {2'b00, shadow_columns};
      default: offset = 8'h40 + {2'b00, shadow_columns};
    endcase
    sum = {1'b0, col} + offset;
    return 8'h80 | {1'b0, sum[6:0]};
  endfunction

  // Append every transaction that an accepted command owes, tagging the last one.
  function automatic void expand_command(lcd_cmd_t c);
    int first_slot;
    first_slot = expected_strobes.size();
    case (c.command)
      clbs_pkg::CMD_INIT: begin
        owe_item(1'b0, 1'b0, 8'h00, US_POWER_ON);
        if (shadow_four_bit) begin
          owe_item(1'b1, 1'b0, 8'h03, US_WAKE_NIB);
          owe_item(1'b1, 1'b0, 8'h03, US_WAKE_NIB);
          owe_item(1'b1, 1'b0, 8'h03, US_WAKE_2ND);
          owe_item(1'b1, 1'b0, 8'h02, US_BYTE);
        end else begin
          owe_byte(1'b0, function_set_byte(), US_EXTRA_WAKE);
          owe_byte(1'b0, function_set_byte(), US_EXTRA_2ND);
          owe_byte(1'b0, function_set_byte(), 16'd0);
        end
        owe_byte(1'b0, function_set_byte(), 16'd0);
        owe_byte(1'b0, 8'h0C, 16'd0);
        owe_byte(1'b0, 8'h01, US_EXTRA_SLOW);
        owe_byte(1'b0, 8'h06, 16'd0);
      end
      clbs_pkg::CMD_CLEAR: owe_byte(1'b0, 8'h01, US_EXTRA_SLOW);
      clbs_pkg::CMD_HOME:  owe_byte(1'b0, 8'h02, US_EXTRA_SLOW);
      clbs_pkg::CMD_MOVE:  owe_byte(1'b0, ddram_address_byte(c.column, c.row), 16'd0);
      clbs_pkg::CMD_WRITE: owe_byte(1'b1, c.data_byte, 16'd0);
      default: ;  // unknown codes owe nothing
    endcase
    if (expected_strobes.size() > first_slot)
      expected_strobes[expected_strobes.size() - 1].last = 1'b1;
  endfunction

  function automatic void apply_reg_write(logic [1:0] idx, logic [5:0] val);
    case (idx)
      clbs_pkg::REG_FOUR_BIT: shadow_four_bit = val[0];
      clbs_pkg::REG_COLUMNS:  shadow_columns = val;
      clbs_pkg::REG_ROWS:     shadow_rows = val[2:0];
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: present the backlog, hold each command until it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : command_driver
    lcd_cmd_t nxt;
    bit       take_gap;
    if (rst) begin
      start <= 1'b0;
    end else begin
      // A command transaction completes here; expand it with the live settings.
      if (start && !busy) begin
        nxt.command = command;
        nxt.data_byte = data_byte;
        nxt.column = column;
        nxt.row = row;
        expand_command(nxt);
      end
      // Hold the current command while busy; otherwise advance or idle.
      if (!start || !busy) begin
        take_gap = gaps_enabled && ($urandom_range(0, 99) < 8);
        if (cmd_backlog.size() != 0 && !take_gap) begin
          nxt = cmd_backlog.pop_front();
          start <= 1'b1;
          command <= nxt.command;
          data_byte <= nxt.data_byte;
          column <= nxt.column;
          row <= nxt.row;
        end else begin
          // Idle: scramble the fields so the block must ignore them.
          start <= 1'b0;
          command <= 3'($urandom);
          data_byte <= 8'($urandom);
          column <= 7'($urandom);
          row <= 3'($urandom);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every strobe must match the oldest owed transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : strobe_monitor
    clbs_pkg::item_t want;
    if (!rst && result_strobe) begin
      if (expected_strobes.size() == 0) begin
        note_mismatch($sformatf("unexpected strobe=%0b rs=%0b bus=%02h wait=%0d last=%0b",
                                strobe_res, reg_select, bus_value, wait_us, last));
      end else begin
        want = expected_strobes.pop_front();
        if (want.strobe_res !== strobe_res || want.reg_select !== reg_select ||
            want.bus_value !== bus_value || want.wait_us !== wait_us ||
            want.last !== last)
          note_mismatch($sformatf(
            "exp strobe=%0b rs=%0b bus=%02h wait=%0d last=%0b, got %0b %0b %02h %0d %0b",
            want.strobe_res, want.reg_select, want.bus_value, want.wait_us, want.last,
            strobe_res, reg_select, bus_value, wait_us, last));
      end
    end
  end

  // Drop the run if no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------

  function automatic void queue_cmd(logic [2:0] c, logic [7:0] b, logic [6:0] x, logic [2:0] y);
    lcd_cmd_t t;
    t.command = c;
    t.data_byte = b;
    t.column = x;
    t.row = y;
    cmd_backlog.push_back(t);
  endfunction

  // Hold until every queued command is taken and every owed strobe has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || start || expected_strobes.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    apply_reg_write(idx, val);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic       four;
    logic [5:0] cols;
    logic [2:0] nrows;
    int         taken;
    int         r;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under reset settings: every command, field extremes,
    // unknown codes, and a cursor row beyond the display.
    queue_cmd(clbs_pkg::CMD_INIT,  8'h00, 7'd0,   3'd0);
    queue_cmd(clbs_pkg::CMD_CLEAR, 8'hFF, 7'd127, 3'd7);
    queue_cmd(clbs_pkg::CMD_HOME,  8'h00, 7'd0,   3'd0);
    queue_cmd(clbs_pkg::CMD_WRITE, 8'h00, 7'd0,   3'd0);
    queue_cmd(clbs_pkg::CMD_WRITE, 8'hFF, 7'd127, 3'd7);
    queue_cmd(clbs_pkg::CMD_WRITE, 8'hA5, 7'd0,   3'd0);
    queue_cmd(clbs_pkg::CMD_MOVE,  8'h00, 7'd0,   3'd0);
    queue_cmd(clbs_pkg::CMD_MOVE,  8'hFF, 7'd127, 3'd7);
    queue_cmd(clbs_pkg::CMD_MOVE,  8'h00, 7'd63,  3'd1);
    queue_cmd(3'd5, 8'h12, 7'd5, 3'd2);
    queue_cmd(3'd6, 8'h34, 7'd6, 3'd3);
    queue_cmd(3'd7, 8'hFF, 7'd127, 3'd7);
    queue_cmd(clbs_pkg::CMD_CLEAR, 8'h5A, 7'd64, 3'd4);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        // An ignored command may still be inside the block; let it settle.
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (phase)
          1: begin four = 1'b0; cols = 6'd40; nrows = 3'd4; end
          2: begin four = 1'b1; cols = 6'd1;  nrows = 3'd2; end
          3: begin four = 1'b0; cols = 6'd63; nrows = 3'd0; end  // rows of zero
          4: begin four = 1'b1; cols = 6'd0;  nrows = 3'd7; end
          5: begin four = 1'b0; cols = 6'd16; nrows = 3'd3; end
          default: begin
            four = 1'($urandom);
            cols = 6'($urandom_range(1, 40));
            nrows = 3'($urandom_range(1, 4));
          end
        endcase
        // Upper data bits are don't-care for the narrower registers.
        write_reg(clbs_pkg::REG_FOUR_BIT, {5'($urandom), four});
        write_reg(clbs_pkg::REG_COLUMNS, cols);
        write_reg(clbs_pkg::REG_ROWS, {3'($urandom), nrows});
        if (phase == 5) write_reg(REG_UNUSED, 6'($urandom));
      end

      // Keep one whole phase free of sender gaps so commands run back to back.
      gaps_enabled = (phase != 2);

      // A fresh init, then a sweep of every cursor row against the current geometry.
      queue_cmd(clbs_pkg::CMD_INIT, 8'($urandom), 7'($urandom), 3'($urandom));
      for (int y = 0; y < 8; y++)
        queue_cmd(clbs_pkg::CMD_MOVE, 8'($urandom), (y % 2) ? 7'd127 : 7'($urandom), 3'(y));

      // Random commands; unknown codes mixed in but not counted.
      taken = 0;
      while (taken < RANDOM_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          queue_cmd(3'($urandom_range(5, 7)), 8'($urandom), 7'($urandom), 3'($urandom));
        end else begin
          queue_cmd(3'($urandom_range(0, 4)), 8'($urandom), 7'($urandom), 3'($urandom));
          taken++;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_strobes.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
